// ===== hw/rtl/cis_pkg.sv =====
// cis_pkg: shared types and codes for the compacting id set
// request and response beat structs, per-cell control struct, status and mode codes
// no dependencies
package cis_pkg;

  localparam int IdW = 20;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NIL     = 3'd1;
  localparam logic [2:0] ST_DUP     = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;

  typedef logic [IdW-1:0] id_t;

  typedef struct packed {
    logic [1:0] mode;
    id_t        id;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] position;
    logic [6:0] count;
  } rsp_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic capture;  // latch compare result for the incoming key
    logic add;      // append key at the current count
    logic remove;   // close the gap left at the hit position
  } cell_ctl_t;

endpackage

// ===== hw/rtl/cis_cell.sv =====
// cis_cell: one storage cell of the id row, holds one entry and its compare result
// takes its right neighbor's entry when a remove closes the gap
// depends on cis_pkg
module cis_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 6,
  parameter int CNT_W = 7
) (
  input  logic              clk,
  input  cis_pkg::cell_ctl_t ctl,
  input  cis_pkg::id_t      key,
  input  logic [CNT_W-1:0]  count,
  input  logic [IDX_W-1:0]  pos,
  input  cis_pkg::id_t      nbr_entry,
  output cis_pkg::id_t      entry,
  output logic              hit
);

  logic live;
  logic at_tail;
  logic in_gap;

  assign live    = CNT_W'(IDX) < count;
  assign at_tail = CNT_W'(IDX) == count;
  // cells from the hit up to the second to last live cell shift down
  assign in_gap  = (IDX_W'(IDX) >= pos) && (CNT_W'(IDX + 1) < count);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      hit <= live && (entry == key);
    end
    if (ctl.add && at_tail) begin
      entry <= key;
    end else if (ctl.remove && in_gap) begin
      entry <= nbr_entry;
    end
  end

endmodule

// ===== hw/rtl/compacting_id_set_unit.sv =====
// compacting_id_set_unit: top level of the compacting id set
// a row of cis_cell storage cells plus request control and the response register
// depends on cis_pkg and cis_cell
//
// Keeps an ordered list of unique 20-bit ids, up to CAPACITY entries.
// Request channel (req_valid / req_stall / req): each beat adds, removes or
// looks up one id. Response channel (rsp_valid / rsp_stall / rsp): one beat
// per request, in order, with status, position and the count afterwards.
// nil_id_we / nil_id_wdata write the reserved nil id; write only while idle.
// Timing: in the accept cycle every cell compares the incoming id with its
// entry in parallel and registers the match at the accepting edge. In the
// next cycle the hits are resolved, the row is updated (append at the tail,
// or shift down past the removed entry) and the response register is loaded.
// The response beat is registered at the end of the resolve cycle, and a new
// request is not taken until the previous one has resolved.
// req_stall is high while a request is in flight. If rsp_stall holds the
// previous response, the resolve cycle waits for it; the state is untouched
// while waiting. The next request may be accepted while a response waits.
// Reset empties the list (count 0), clears nil_id to 0 and drops any
// pending response; the entry storage itself is not cleared.
module compacting_id_set_unit #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          nil_id_we,
  input  cis_pkg::id_t  nil_id_wdata,
  input  logic          req_valid,
  output logic          req_stall,
  input  cis_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output cis_pkg::rsp_t rsp
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic               state;
  logic               state_next;
  cis_pkg::id_t       nil_id;
  cis_pkg::id_t       key;
  cis_pkg::id_t       cell_key;
  logic [1:0]         mode;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;

  cis_pkg::cell_ctl_t ctl;
  cis_pkg::id_t       entry [CAPACITY];
  logic [CAPACITY-1:0] hit;

  logic               req_take;
  logic               done;
  logic               found;
  logic [IDX_W-1:0]   hit_pos;
  logic [IDX_W-1:0]   res_pos;
  logic [2:0]         res_status;
  logic [IDX_W+5:0]   pos_ext;
  logic [CNT_W+6:0]   cnt_ext;

  assign req_stall = (state == ST_BUSY);
  assign req_take  = req_valid && !req_stall;
  assign done      = (state == ST_BUSY) && !(rsp_valid && rsp_stall);

  // compare against the incoming id, append the held one
  assign cell_key  = req_take ? req.id : key;

  // ids are unique in the row, so at most one cell hits and an or is enough
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) begin
        hit_pos = hit_pos | IDX_W'(i);
      end
    end
  end
  assign found = |hit;

  always_comb begin
    res_status = cis_pkg::ST_OK;
    res_pos    = '0;
    count_next = count;
    ctl        = '0;
    ctl.capture = req_take;
    case (mode)
      cis_pkg::MODE_ADD: begin
        if (key == nil_id) begin
          res_status = cis_pkg::ST_NIL;
        end else if (count >= CNT_W'(CAPACITY)) begin
          res_status = cis_pkg::ST_FULL;
        end else if (found) begin
          res_status = cis_pkg::ST_DUP;
        end else begin
          res_pos    = count[IDX_W-1:0];
          count_next = count + CNT_W'(1);
          ctl.add    = done;
        end
      end
      cis_pkg::MODE_REMOVE: begin
        if (found) begin
          res_pos    = hit_pos;
          count_next = count - CNT_W'(1);
          ctl.remove = done;
        end else begin
          res_status = cis_pkg::ST_MISSING;
        end
      end
      default: begin
        if (found) begin
          res_pos = hit_pos;
        end else begin
          res_status = cis_pkg::ST_MISSING;
        end
      end
    endcase
  end

  assign pos_ext = {6'b0, res_pos};
  assign cnt_ext = {7'b0, count_next};

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    cis_pkg::id_t nbr;
    if (g == CAPACITY - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = entry[g+1];
    end
    cis_cell #(
      .IDX   (g),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .key       (cell_key),
      .count     (count),
      .pos       (hit_pos),
      .nbr_entry (nbr),
      .entry     (entry[g]),
      .hit       (hit[g])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (req_take) state_next = ST_BUSY;
      ST_BUSY: if (done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      nil_id    <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (nil_id_we) begin
        nil_id <= nil_id_wdata;
      end
      if (done) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      key  <= req.id;
      mode <= req.mode;
    end
    if (done) begin
      rsp.status   <= res_status;
      rsp.position <= pos_ext[5:0];
      rsp.count    <= cnt_ext[6:0];
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BUSY) |-> $onehot0(hit))
    else $error("more than one cell matched the key");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    req_take |=> (state == ST_BUSY))
    else $error("accepted request did not start");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !done |=> $stable(count))
    else $error("count changed without a completed request");

  a_rsp_on_done: assert property (@(posedge clk) disable iff (rst)
    done |=> rsp_valid)
    else $error("completed request left no response");

endmodule

// ===== verif/tb.sv =====
// tb: self-checking testbench for compacting_id_set_unit
// drives add/remove/lookup beats against a shadow copy of the id list and checks every response
// depends on cis_pkg and the compacting_id_set_unit rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 64;
  localparam logic [1:0] MODE_SPARE = 2'd3;  // unused encoding, behaves as a lookup

  logic clk;
  logic rst = 1'b1;
  logic nil_id_we = 1'b0;
  cis_pkg::id_t nil_id_wdata = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  cis_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  cis_pkg::rsp_t rsp;

  compacting_id_set_unit #(.CAPACITY(CAPACITY)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .nil_id_we    (nil_id_we),
    .nil_id_wdata (nil_id_wdata),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp)
  );

  // shadow of the id list
  cis_pkg::id_t shadow_ids [CAPACITY];
  int shadow_count = 0;
  cis_pkg::id_t shadow_nil = '0;

  cis_pkg::rsp_t awaited_rsp_q [$];
  int send_idle_pct = 22;
  int rcv_stall_pct = 49;
  int n_sent = 0;
  int n_checked = 0;
  int n_fail = 0;
  int n_full_rsp = 0;
  int n_removed = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d responses outstanding", awaited_rsp_q.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic int find_shadow(cis_pkg::id_t key);
    for (int k = 0; k < shadow_count; k++)
      if (shadow_ids[k] == key) return k;
    return -1;
  endfunction

  // applies one request to the shadow list and returns the response it should produce
  function automatic cis_pkg::rsp_t update_shadow_set(cis_pkg::req_t r);
    cis_pkg::rsp_t o;
    int hit;
    o = '0;
    hit = find_shadow(r.id);
    case (r.mode)
      cis_pkg::MODE_ADD: begin
        if (r.id == shadow_nil) o.status = cis_pkg::ST_NIL;
        else if (shadow_count >= CAPACITY) o.status = cis_pkg::ST_FULL;
        else if (hit >= 0) o.status = cis_pkg::ST_DUP;
        else begin
          o.position = 6'(shadow_count);
          shadow_ids[shadow_count] = r.id;
          shadow_count++;
        end
      end
      cis_pkg::MODE_REMOVE: begin
        if (hit < 0) o.status = cis_pkg::ST_MISSING;
        else begin
          o.position = 6'(hit);
          for (int k = hit; k + 1 < shadow_count; k++) shadow_ids[k] = shadow_ids[k + 1];
          shadow_count--;
        end
      end
      default: begin
        if (hit < 0) o.status = cis_pkg::ST_MISSING;
        else o.position = 6'(hit);
      end
    endcase
    o.count = 7'(shadow_count);
    return o;
  endfunction

  function automatic cis_pkg::id_t unused_id();
    cis_pkg::id_t key;
    key = cis_pkg::id_t'($urandom);
    while (key == shadow_nil || find_shadow(key) >= 0) key = cis_pkg::id_t'($urandom);
    return key;
  endfunction

  always @(negedge clk) rsp_stall <= ($urandom_range(99) < rcv_stall_pct);

  always @(posedge clk) begin
    cis_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_rsp_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("unexpected response beat: status %0d position %0d count %0d",
                   rsp.status, rsp.position, rsp.count);
      end else begin
        want = awaited_rsp_q.pop_front();
        n_checked++;
        if (want.status == cis_pkg::ST_FULL) n_full_rsp++;
        if (rsp.status != want.status || rsp.position != want.position ||
            rsp.count != want.count) begin
          n_fail++;
          if (n_fail <= 10)
            $display({"response %0d mismatch: expected status %0d position %0d count %0d,",
                      " got %0d %0d %0d"},
                     n_checked, want.status, want.position, want.count,
                     rsp.status, rsp.position, rsp.count);
        end
      end
    end
  end

  task automatic send_request(logic [1:0] mode, cis_pkg::id_t key);
    cis_pkg::req_t r;
    r.mode = mode;
    r.id = key;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    if (mode == cis_pkg::MODE_REMOVE && find_shadow(key) >= 0) n_removed++;
    awaited_rsp_q.push_back(update_shadow_set(r));
    n_sent++;
  endtask

  // hold off new beats until every response has drained
  task automatic quiesce();
    @(negedge clk);
    req_valid <= 1'b0;
    while (awaited_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_nil_id(cis_pkg::id_t value);
    quiesce();
    @(negedge clk);
    nil_id_we <= 1'b1;
    nil_id_wdata <= value;
    @(negedge clk);
    nil_id_we <= 1'b0;
    shadow_nil = value;
  endtask

  task automatic test_basic_ops();
    send_request(cis_pkg::MODE_LOOKUP, 20'h00000);   // nil id on an empty list
    send_request(cis_pkg::MODE_REMOVE, 20'hFFFFF);
    send_request(cis_pkg::MODE_ADD, 20'h00000);
    send_request(cis_pkg::MODE_ADD, 20'hFFFFF);
    send_request(cis_pkg::MODE_ADD, 20'h00001);
    send_request(cis_pkg::MODE_ADD, 20'h80000);
    send_request(cis_pkg::MODE_ADD, 20'h7FFFF);
    send_request(cis_pkg::MODE_ADD, 20'h00001);
    send_request(cis_pkg::MODE_LOOKUP, 20'h7FFFF);
    send_request(MODE_SPARE, 20'h80000);
    send_request(MODE_SPARE, 20'h00005);
    send_request(cis_pkg::MODE_REMOVE, 20'h00001);  // tail shifts down
    send_request(cis_pkg::MODE_LOOKUP, 20'h7FFFF);
    send_request(cis_pkg::MODE_REMOVE, 20'hFFFFF);
    send_request(cis_pkg::MODE_REMOVE, 20'hFFFFF);
  endtask

  // an entry that matches a newly written nil id is still found and removable
  task automatic test_nil_change();
    write_nil_id(20'h80000);
    send_request(cis_pkg::MODE_LOOKUP, 20'h80000);
    send_request(cis_pkg::MODE_ADD, 20'h80000);
    send_request(cis_pkg::MODE_REMOVE, 20'h80000);
    send_request(cis_pkg::MODE_LOOKUP, 20'h80000);
    send_request(cis_pkg::MODE_ADD, 20'h00000);
    write_nil_id(20'hFFFFF);
    send_request(cis_pkg::MODE_ADD, 20'hFFFFF);
    send_request(cis_pkg::MODE_REMOVE, 20'hFFFFF);
  endtask

  task automatic test_full_list();
    cis_pkg::id_t tail_id;
    write_nil_id(cis_pkg::id_t'($urandom));
    while (shadow_count < CAPACITY) send_request(cis_pkg::MODE_ADD, unused_id());
    tail_id = shadow_ids[CAPACITY - 1];
    send_request(cis_pkg::MODE_ADD, shadow_nil);     // nil wins over full
    send_request(cis_pkg::MODE_ADD, shadow_ids[5]);  // full wins over duplicate
    send_request(cis_pkg::MODE_ADD, unused_id());
    send_request(cis_pkg::MODE_LOOKUP, tail_id);
    send_request(cis_pkg::MODE_REMOVE, shadow_ids[0]);
    send_request(cis_pkg::MODE_LOOKUP, tail_id);
    send_request(cis_pkg::MODE_ADD, tail_id);
    send_request(cis_pkg::MODE_ADD, unused_id());
  endtask

  task automatic random_burst(int n, int add_pct);
    logic [1:0] mode;
    cis_pkg::id_t key;
    int pick;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < add_pct) mode = cis_pkg::MODE_ADD;
      else if (pick < 85) mode = cis_pkg::MODE_REMOVE;
      else if (pick < 95) mode = cis_pkg::MODE_LOOKUP;
      else mode = MODE_SPARE;
      pick = $urandom_range(99);
      if (pick < 8) key = shadow_nil;
      else if (pick < 50 && shadow_count > 0)
        key = shadow_ids[$urandom_range(shadow_count - 1)];
      else if (pick < 60) key = cis_pkg::id_t'($urandom_range(15));
      else key = cis_pkg::id_t'($urandom);
      send_request(mode, key);
    end
  endtask

  // list grows to full, drains, and grows again with a full pause midway
  task automatic test_random_traffic(int idle_pct, int stall_pct, cis_pkg::id_t nil_value);
    write_nil_id(nil_value);
    send_idle_pct = idle_pct;
    rcv_stall_pct = stall_pct;
    random_burst(140, 70);
    random_burst(140, 15);
    quiesce();
    random_burst(100, 70);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_ops();
    test_nil_change();
    test_full_list();
    test_random_traffic(22, 49, 20'h00000);
    test_random_traffic(49, 22, cis_pkg::id_t'($urandom));
    test_random_traffic(0, 0, 20'hFFFFF);

    quiesce();
    repeat (8) @(posedge clk);
    $display("covered %0d request beats, %0d responses checked, %0d removals", n_sent,
             n_checked, n_removed);
    $display("full-list rejections seen: %0d, nil id settings exercised incl. all-0/all-1",
             n_full_rsp);
    if (n_fail == 0 && awaited_rsp_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures", n_fail);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
